// ===== rtl/bdq_pkg.sv =====
// shared types, operation codes and status codes for the bounded deque
`default_nettype none

package bdq_pkg;

  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int VALUE_W     = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_DISPLAY    = 3'd2;
  localparam op_t OP_SEARCH     = 3'd3;
  localparam op_t OP_POP_FRONT  = 3'd4;
  localparam op_t OP_POP_BACK   = 3'd5;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_EMPTY     = 2'd1;
  localparam status_t STAT_FULL      = 2'd2;
  localparam status_t STAT_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/bdq_ring.sv =====
// shared ring index unit: (base + offset) modulo the capacity
`default_nettype none

module bdq_ring #(
  parameter int CAPACITY = 16,
  parameter int IW       = 4
) (
  input  wire logic [IW-1:0] base,
  input  wire logic [IW-1:0] offset,
  output logic      [IW-1:0] slot
);

  logic [IW:0] sum;
  logic        wrap;

  // both operands stay below the capacity, so one compare and subtract wraps
  assign sum  = {1'b0, base} + {1'b0, offset};
  assign wrap = sum >= (IW+1)'(CAPACITY);
  assign slot = wrap ? IW'(sum - (IW+1)'(CAPACITY)) : IW'(sum);

endmodule

`default_nettype wire

// ===== rtl/bdq_store.sv =====
// entry memory: one write or read address per cycle, registered read data
`default_nettype none

module bdq_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read register holds its value between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_deque_with_search.sv =====
// top level of the bounded deque with search: sequencer, output register
`default_nettype none

// Bounded double-ended queue of signed values held in a ring buffer memory.
// Each input beat carries one operation on in_tuser and its value on in_tdata:
// push front, push back, display, search, pop front or pop back; codes 6 and 7
// are ignored and give no beat. Each result beat carries its status on
// out_tuser and its value on out_tdata. Pushes and pops give one result beat;
// a push into a full queue is dropped with status full, a pop, search or
// display of an empty queue gives status empty. Search scans front to back
// and returns the first equal value or status not found. Display gives one
// beat per held value, front to back, with tlast on the final one; every other
// operation gives a single beat with tlast set. Items are handled one at a
// time: in_tready is high only while the sequencer is idle. A push then
// passes the push and response states, a pop the read, compare and response
// states, a search a read and compare per entry scanned and then a response,
// and a display a read and a send per entry, since every entry goes through
// the single memory port with a registered read and the single ring index
// adder; each stretches while the sink holds off. Result beats wait in an
// output register, so a new item is accepted while the last result is still
// pending. The memory is not cleared after reset; only entries that were
// pushed are ever read.
module bounded_deque_with_search #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [31:0] value
  input  wire logic [bdq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: [2:0] operation
  input  wire logic [bdq_pkg::OP_W-1:0]           in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: [31:0] result_value
  output logic      [bdq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: [1:0] status
  output logic      [bdq_pkg::STATUS_W-1:0]       out_tuser,
  output logic                                    out_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  // input beat fields
  bdq_pkg::op_t                         in_op;
  logic signed [bdq_pkg::VALUE_W-1:0]   in_value;
  logic signed [DATA_WIDTH-1:0]         in_value_dw;

  assign in_op       = in_tuser;
  assign in_value    = in_tdata[bdq_pkg::VALUE_W-1:0];
  assign in_value_dw = DATA_WIDTH'(in_value);

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  // item being worked on
  bdq_pkg::op_t                 op_r, op_nxt;
  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;

  // staged single-beat response
  bdq_pkg::status_t             resp_status_r, resp_status_nxt;
  logic signed [DATA_WIDTH-1:0] resp_value_r, resp_value_nxt;

  // output register
  logic                               out_valid_r, out_valid_nxt;
  bdq_pkg::status_t                   out_status_r, out_status_nxt;
  logic signed [bdq_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                               out_last_r, out_last_nxt;

  // memory and ring unit hookup
  logic                         mem_we;
  logic                         mem_re;
  logic [IW-1:0]                ring_off;
  logic [IW-1:0]                ring_slot;
  logic signed [DATA_WIDTH-1:0] rd_data;

  logic out_free;
  logic is_full;
  logic is_empty;
  logic idx_last;

  assign out_free = !out_valid_r || out_tready;
  assign is_full  = count_r == CW'(CAPACITY);
  assign is_empty = count_r == '0;
  assign idx_last = idx_r == IW'(count_r - CW'(1));

  bdq_ring #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ring (
    .base   (front_r),
    .offset (ring_off),
    .slot   (ring_slot)
  );

  bdq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (ring_slot),
    .wdata (val_r),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    op_nxt          = op_r;
    val_nxt         = val_r;
    resp_status_nxt = resp_status_r;
    resp_value_nxt  = resp_value_r;
    // pending beat leaves when the sink takes it
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_value_nxt   = out_value_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    ring_off        = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_op;
          val_nxt = in_value_dw;
          idx_nxt = '0;
          case (in_op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                resp_status_nxt = bdq_pkg::STAT_FULL;
                resp_value_nxt  = '0;
                state_nxt       = S_RESP;
              end else begin
                state_nxt = S_PUSH;
              end
            end
            bdq_pkg::OP_DISPLAY, bdq_pkg::OP_SEARCH, bdq_pkg::OP_POP_FRONT,
            bdq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                resp_status_nxt = bdq_pkg::STAT_EMPTY;
                resp_value_nxt  = '0;
                state_nxt       = S_RESP;
              end else begin
                // pop back reads the tail entry, the rest start at the front
                if (in_op == bdq_pkg::OP_POP_BACK) begin
                  idx_nxt = IW'(count_r - CW'(1));
                end
                state_nxt = S_RD;
              end
            end
            default: begin
              // undefined operation: dropped without a result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_PUSH: begin
        // push front goes one slot before the front, push back after the tail
        if (op_r == bdq_pkg::OP_PUSH_FRONT) begin
          ring_off  = IW'(CAPACITY - 1);
          front_nxt = ring_slot;
        end else begin
          ring_off = IW'(count_r);
        end
        mem_we          = 1'b1;
        count_nxt       = count_r + CW'(1);
        resp_status_nxt = bdq_pkg::STAT_OK;
        resp_value_nxt  = '0;
        state_nxt       = S_RESP;
      end

      S_RD: begin
        ring_off  = idx_r;
        mem_re    = 1'b1;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        case (op_r)
          bdq_pkg::OP_DISPLAY: begin
            // one beat per entry, straight from the read register
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bdq_pkg::STAT_OK;
              out_value_nxt  = bdq_pkg::VALUE_W'(rd_data);
              out_last_nxt   = idx_last;
              if (idx_last) begin
                state_nxt = S_IDLE;
              end else begin
                idx_nxt   = idx_r + IW'(1);
                state_nxt = S_RD;
              end
            end
          end
          bdq_pkg::OP_SEARCH: begin
            if (rd_data == val_r) begin
              resp_status_nxt = bdq_pkg::STAT_OK;
              resp_value_nxt  = rd_data;
              state_nxt       = S_RESP;
            end else if (idx_last) begin
              resp_status_nxt = bdq_pkg::STAT_NOT_FOUND;
              resp_value_nxt  = '0;
              state_nxt       = S_RESP;
            end else begin
              idx_nxt   = idx_r + IW'(1);
              state_nxt = S_RD;
            end
          end
          bdq_pkg::OP_POP_FRONT: begin
            // front moves one slot on through the ring unit
            ring_off        = IW'(1);
            front_nxt       = ring_slot;
            count_nxt       = count_r - CW'(1);
            resp_status_nxt = bdq_pkg::STAT_OK;
            resp_value_nxt  = rd_data;
            state_nxt       = S_RESP;
          end
          default: begin
            // pop back: only the count shrinks
            count_nxt       = count_r - CW'(1);
            resp_status_nxt = bdq_pkg::STAT_OK;
            resp_value_nxt  = rd_data;
            state_nxt       = S_RESP;
          end
        endcase
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_value_nxt  = bdq_pkg::VALUE_W'(resp_value_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    resp_status_r <= resp_status_nxt;
    resp_value_r  <= resp_value_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_value_r;

  // the held count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // the count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
             (count_r == $past(count_r) - CW'(1)))
    else $error("entry count jumped");

  // only display beats go out without tlast, and they are always ok
  a_mid_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_status_r == bdq_pkg::STAT_OK)
    else $error("non-final beat with error status");

  // error statuses carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != bdq_pkg::STAT_OK) |-> out_value_r == '0)
    else $error("error status with nonzero value");

endmodule

`default_nettype wire

// ===== tb/sv/deque_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard class for the bounded deque: ring buffer predictor and result beat checker
package deque_scoreboard_pkg;

  localparam int DEPTH = 16;

  typedef struct packed {
    bdq_pkg::status_t status;
    logic [31:0]      value;
    logic             last;
  } beat_t;

  class deque_scoreboard;
    logic [31:0] slots [DEPTH];
    int          head;
    int          held;
    beat_t       expected_beats [$];
    int          mismatches;

    function new();
      head       = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    function int slot_at(int offset);
      return (head + offset) % DEPTH;
    endfunction

    function logic [31:0] held_value(int offset);
      return slots[slot_at(offset)];
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void queue_beat(bdq_pkg::status_t status, logic [31:0] value, logic last);
      beat_t b;
      b.status = status;
      b.value  = value;
      b.last   = last;
      expected_beats.push_back(b);
    endfunction

    // update the deque copy for one accepted operation and queue its result beats
    function void note_op(bdq_pkg::op_t op, logic [31:0] value);
      int i;
      int hit;
      case (op)
        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            queue_beat(bdq_pkg::STAT_FULL, '0, 1'b1);
          end else begin
            if (op == bdq_pkg::OP_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              slots[head] = value;
            end else begin
              slots[slot_at(held)] = value;
            end
            held++;
            queue_beat(bdq_pkg::STAT_OK, '0, 1'b1);
          end
        end
        bdq_pkg::OP_DISPLAY: begin
          if (held == 0) begin
            queue_beat(bdq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < held; i++)
              queue_beat(bdq_pkg::STAT_OK, slots[slot_at(i)], i == held - 1);
          end
        end
        bdq_pkg::OP_SEARCH: begin
          if (held == 0) begin
            queue_beat(bdq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            hit = -1;
            // first match wins, scanning front to back
            for (i = 0; i < held && hit < 0; i++)
              if (slots[slot_at(i)] == value) hit = slot_at(i);
            if (hit >= 0) queue_beat(bdq_pkg::STAT_OK, slots[hit], 1'b1);
            else queue_beat(bdq_pkg::STAT_NOT_FOUND, '0, 1'b1);
          end
        end
        bdq_pkg::OP_POP_FRONT: begin
          if (held == 0) begin
            queue_beat(bdq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            queue_beat(bdq_pkg::STAT_OK, slots[head], 1'b1);
            head = slot_at(1);
            held--;
          end
        end
        bdq_pkg::OP_POP_BACK: begin
          if (held == 0) begin
            queue_beat(bdq_pkg::STAT_EMPTY, '0, 1'b1);
          end else begin
            queue_beat(bdq_pkg::STAT_OK, slots[slot_at(held - 1)], 1'b1);
            held--;
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, beat_t want, beat_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected status %0d value %h last %0b, got status %0d value %h last %0b",
                 what, want.status, want.value, want.last, got.status, got.value, got.last);
    endfunction

    // compare one accepted result beat with the oldest expected beat
    function void check_beat(bdq_pkg::status_t tuser, logic [bdq_pkg::OUT_TDATA_W-1:0] tdata,
                             logic tlast);
      beat_t got;
      beat_t want;
      got.status = tuser;
      got.value  = tdata[31:0];
      got.last   = tlast;
      if (expected_beats.size() == 0) begin
        report("unexpected result beat", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) report("result mismatch", want, got);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the bounded deque: directed and random operations, scoreboard check
module tb;

  localparam int DEPTH = deque_scoreboard_pkg::DEPTH;

  // codes 6 and 7 are not operations; the block must swallow them silently
  localparam bdq_pkg::op_t OP_UNUSED_6 = 3'd6;
  localparam bdq_pkg::op_t OP_UNUSED_7 = 3'd7;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 40;    // longer than a full search of every entry
  localparam int PHASE_ITEMS  = 26;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [bdq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  bdq_pkg::op_t                    in_tuser = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [bdq_pkg::OUT_TDATA_W-1:0] out_tdata;
  bdq_pkg::status_t                out_tuser;
  logic                            out_tlast;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;

  // percent of cycles in which each side holds off
  int tx_idle_pct = 21;
  int rx_idle_pct = 53;

  deque_scoreboard_pkg::deque_scoreboard sb;
  int              quiet_cycles = 0;
  bit              growing = 1'b1;

  always #10 clk = ~clk;

  bounded_deque_with_search #(
    .CAPACITY   (DEPTH),
    .DATA_WIDTH (32)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // beat monitor on both channels, plus the stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_op(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_beat(out_tuser, out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // present one input beat and hold it until the block takes it
  task automatic send_op(bdq_pkg::op_t op, logic [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // extremes, small values that repeat, and full random words
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // random mix that swings the deque between empty and full
  task automatic random_items(int count);
    int           done;
    int           r;
    bdq_pkg::op_t op;
    logic [31:0]  value;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 4) begin
        // noise that gives no result
        send_op(r < 2 ? OP_UNUSED_6 : OP_UNUSED_7, $urandom);
        continue;
      end
      // hang around full or empty for a few items before turning
      if (sb.held == DEPTH && $urandom_range(1) == 0) growing = 1'b0;
      if (sb.held == 0 && $urandom_range(1) == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 8) op = bdq_pkg::OP_DISPLAY;
      else if (r < 22) op = bdq_pkg::OP_SEARCH;
      else if (r < (growing ? 92 : 37))
        op = $urandom_range(1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
      else op = $urandom_range(1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
      if (op == bdq_pkg::OP_SEARCH && sb.held > 0 && $urandom_range(9) < 6)
        value = sb.held_value($urandom_range(sb.held - 1));
      else
        value = pick_value();
      send_op(op, value);
      done++;
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every read and pop on an empty deque, and the two unused codes
    send_op(bdq_pkg::OP_DISPLAY, 32'h0);
    send_op(bdq_pkg::OP_SEARCH, 32'h0);
    send_op(bdq_pkg::OP_POP_FRONT, 32'h0);
    send_op(bdq_pkg::OP_POP_BACK, 32'h0);
    send_op(OP_UNUSED_6, 32'hffff_ffff);
    send_op(OP_UNUSED_7, 32'h5a5a_a5a5);

    // both ends, with the front wrapping below slot zero
    send_op(bdq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
    send_op(bdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_op(bdq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_op(bdq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
    send_op(bdq_pkg::OP_PUSH_BACK, 32'h0000_0001);
    send_op(bdq_pkg::OP_DISPLAY, 32'h0);

    // hits at several positions and a miss
    send_op(bdq_pkg::OP_SEARCH, 32'h0000_0000);
    send_op(bdq_pkg::OP_SEARCH, 32'h8000_0000);
    send_op(bdq_pkg::OP_SEARCH, 32'h7fff_ffff);
    send_op(bdq_pkg::OP_SEARCH, 32'h0001_2345);

    // drain from both ends down to empty and one past
    send_op(bdq_pkg::OP_POP_FRONT, 32'h0);
    send_op(bdq_pkg::OP_POP_BACK, 32'h0);
    send_op(bdq_pkg::OP_DISPLAY, 32'h0);
    send_op(bdq_pkg::OP_POP_BACK, 32'h0);
    send_op(bdq_pkg::OP_POP_FRONT, 32'h0);
    send_op(bdq_pkg::OP_POP_FRONT, 32'h0);
    send_op(bdq_pkg::OP_POP_BACK, 32'h0);

    random_items(PHASE_ITEMS);
    tx_idle_pct = 53;
    rx_idle_pct = 21;
    random_items(PHASE_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(PHASE_ITEMS);
    in_tvalid <= 1'b0;

    // let outstanding beats drain, then watch for stray ones
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bdq_pkg.sv
rtl/bdq_ring.sv
rtl/bdq_store.sv
rtl/bounded_deque_with_search.sv
tb/sv/deque_scoreboard_pkg.sv
tb/sv/tb.sv
